[hdl/swing_foot_bezier_trajectory_top_defines.svh]
// Assertion macros for the swing foot trajectory block.
// Used by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SWING_FOOT_BEZIER_TRAJECTORY_TOP_DEFINES_SVH
`define SWING_FOOT_BEZIER_TRAJECTORY_TOP_DEFINES_SVH
`ifndef SYNTH
`define SFB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfb assertion failed");
`define SFB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfb assertion failed");
`else
`define SFB_ASSERT_IMP(lbl, ante, cons)
`define SFB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/sfb_pkg.sv]
// Shared types, constants and helpers for the swing foot trajectory block.
// No dependencies.
package sfb_pkg;

    localparam int LEGS          = 4;
    localparam int POS_FRAC_BITS = 20;

    localparam logic [23:0] PERIOD_RESET = 24'd250000;
    localparam logic signed [23:0] Z_OUTER_RESET =
        24'(-((325 * (1 << POS_FRAC_BITS)) / 1000));
    localparam logic signed [23:0] Z_INNER_RESET = 24'(-(1 << (POS_FRAC_BITS - 2)));

    localparam logic [18:0] PHASE_MAX = 19'd262144;
    localparam logic [19:0] US_PER_S  = 20'd1000000;

    localparam logic [5:0] DIV_STEPS_PHASE = 6'd48;
    localparam logic [5:0] DIV_STEPS_VEL   = 6'd32;
    localparam logic [3:0] LERP_LAST       = 4'd8;

    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        CFG_PERIOD = 3'd0,
        CFG_Z0     = 3'd1,
        CFG_Z1     = 3'd2,
        CFG_Z2     = 3'd3,
        CFG_Z3     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic       store;
        logic       capture;
        logic       div_step;
        logic       div_load_vel;
        logic       phase_take;
        logic       coef_mul;
        logic       coef_fin;
        logic       axis_load;
        logic       wshift;
        logic       lerp_mul;
        logic       lerp_add;
        logic       pos_take;
        logic       vmul;
        logic       vclr;
        logic       vacc;
        logic       vround;
        logic       vscale;
        logic       vtake;
        logic       result_load;
        logic [1:0] axis;
        logic [1:0] vk;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } sts_t;

    // de Casteljau on a shift line: steps that only drop a spent point
    function automatic logic lerp_is_shift(input logic [3:0] step);
        return step inside {4'd3, 4'd6, 4'd7};
    endfunction

    // floor((3a + b) / 4)
    function automatic logic signed [23:0] inner_pt(input logic signed [23:0] a,
                                                   input logic signed [23:0] b);
        logic signed [26:0] s;
        s = (27'(a) <<< 1) + 27'(a) + 27'(b);
        return s[25:2];
    endfunction

endpackage

[hdl/swing_foot_bezier_trajectory_top.sv]
// A query holds in_ready low from its input transfer until its result is loaded for output.
// Set items are taken back to back while idle. Queries use the 1-bit-per-cycle divider
// (48 steps for phase, 32 per velocity axis) and the shared lerp multiplier.
// rst_n returns the configuration registers to their reset values and every leg entry to zero.
// Top level: configuration registers, controller and datapath. Depends on sfb_pkg.
module swing_foot_bezier_trajectory_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [1:0]         leg,
    input  logic [31:0]        now_time,
    input  logic signed [23:0] start_x,
    input  logic signed [23:0] start_y,
    input  logic signed [23:0] end_x,
    input  logic signed [23:0] end_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         leg_out,
    output logic signed [23:0] pos_x,
    output logic signed [23:0] pos_y,
    output logic signed [23:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic               vel_saturated
);

    logic [23:0]        period_reg;
    logic signed [23:0] z0_reg, z1_reg, z2_reg, z3_reg;
    logic [23:0]        period_eff;
    sfb_pkg::cmd_t      cmd;
    sfb_pkg::sts_t      sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= sfb_pkg::PERIOD_RESET;
            z0_reg     <= sfb_pkg::Z_OUTER_RESET;
            z1_reg     <= sfb_pkg::Z_INNER_RESET;
            z2_reg     <= sfb_pkg::Z_INNER_RESET;
            z3_reg     <= sfb_pkg::Z_OUTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfb_pkg::CFG_PERIOD: period_reg <= cfg_data;
                sfb_pkg::CFG_Z0:     z0_reg     <= cfg_data;
                sfb_pkg::CFG_Z1:     z1_reg     <= cfg_data;
                sfb_pkg::CFG_Z2:     z2_reg     <= cfg_data;
                sfb_pkg::CFG_Z3:     z3_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // zero period behaves as one microsecond
    assign period_eff = (period_reg == '0) ? 24'd1 : period_reg;

    sfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .leg           (leg),
        .now_time      (now_time),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .period        (period_eff),
        .z_point0      (z0_reg),
        .z_point1      (z1_reg),
        .z_point2      (z2_reg),
        .z_point3      (z3_reg),
        .leg_out       (leg_out),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .vel_saturated (vel_saturated)
    );

endmodule

[hdl/sfb_ctrl.sv]
// Sequencer for the swing foot trajectory block.
// Depends on sfb_pkg and the assertion macro header.
`include "swing_foot_bezier_trajectory_top_defines.svh"
module sfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  sfb_pkg::sts_t     sts,
    output sfb_pkg::cmd_t     cmd
);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_PDIV  = 16'b0000_0000_0000_0010,
        ST_PTAKE = 16'b0000_0000_0000_0100,
        ST_CMUL  = 16'b0000_0000_0000_1000,
        ST_CFIN  = 16'b0000_0000_0001_0000,
        ST_AXIS  = 16'b0000_0000_0010_0000,
        ST_LMUL  = 16'b0000_0000_0100_0000,
        ST_LADD  = 16'b0000_0000_1000_0000,
        ST_VMUL  = 16'b0000_0001_0000_0000,
        ST_VSUM  = 16'b0000_0010_0000_0000,
        ST_VRND  = 16'b0000_0100_0000_0000,
        ST_VSCL  = 16'b0000_1000_0000_0000,
        ST_VDLD  = 16'b0001_0000_0000_0000,
        ST_VDIV  = 16'b0010_0000_0000_0000,
        ST_VSAT  = 16'b0100_0000_0000_0000,
        ST_OUT   = 16'b1000_0000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] vk_reg, vk_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            vk_reg        <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            vk_reg        <= vk_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        vk_next    = vk_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.vk     = vk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == sfb_pkg::KIND_QUERY)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_PDIV;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_PDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_PTAKE;
                end
            end
            ST_PTAKE:
            begin
                cmd.phase_take = 1'b1;
                state_next     = ST_CMUL;
            end
            ST_CMUL:
            begin
                cmd.coef_mul = 1'b1;
                state_next   = ST_CFIN;
            end
            ST_CFIN:
            begin
                cmd.coef_fin = 1'b1;
                axis_next    = 2'd0;
                state_next   = ST_AXIS;
            end
            ST_AXIS:
            begin
                cmd.axis_load = 1'b1;
                step_next     = '0;
                state_next    = ST_LMUL;
            end
            ST_LMUL:
            begin
                if (sfb_pkg::lerp_is_shift(step_reg))
                begin
                    cmd.wshift = 1'b1;
                    step_next  = step_reg + 4'd1;
                end
                else
                begin
                    cmd.lerp_mul = 1'b1;
                    state_next   = ST_LADD;
                end
            end
            ST_LADD:
            begin
                cmd.lerp_add = 1'b1;
                if (step_reg == sfb_pkg::LERP_LAST)
                begin
                    vk_next    = 2'd0;
                    state_next = ST_VMUL;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_LMUL;
                end
            end
            ST_VMUL:
            begin
                cmd.vmul = 1'b1;
                if (vk_reg == 2'd0)
                begin
                    cmd.vclr     = 1'b1;
                    cmd.pos_take = 1'b1;
                end
                else
                begin
                    cmd.vacc = 1'b1;
                end
                if (vk_reg == 2'd2)
                begin
                    state_next = ST_VSUM;
                end
                else
                begin
                    vk_next = vk_reg + 2'd1;
                end
            end
            ST_VSUM:
            begin
                cmd.vacc   = 1'b1;
                state_next = ST_VRND;
            end
            ST_VRND:
            begin
                cmd.vround = 1'b1;
                state_next = ST_VSCL;
            end
            ST_VSCL:
            begin
                cmd.vscale = 1'b1;
                state_next = ST_VDLD;
            end
            ST_VDLD:
            begin
                cmd.div_load_vel = 1'b1;
                state_next       = ST_VDIV;
            end
            ST_VDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_VSAT;
                end
            end
            ST_VSAT:
            begin
                cmd.vtake = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_AXIS;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `SFB_ASSERT_IMP(a_result_from_out, $rose(out_valid_reg), $past(state_reg == ST_OUT))
    `SFB_ASSERT_IMP(a_axis_range, state_reg == ST_VSAT, axis_reg <= 2'd2)
    `SFB_ASSERT_NXT(a_no_overwrite, (state_reg == ST_OUT) && out_valid_reg && !out_ready,
                    state_reg == ST_OUT)
    `SFB_ASSERT_IMP(a_lerp_step_range, state_reg == ST_LADD, step_reg <= sfb_pkg::LERP_LAST)

endmodule

[hdl/sfb_datapath.sv]
// Datapath: leg store, shared restoring divider, de Casteljau lerp unit,
// velocity coefficient and scaling arithmetic, result registers. Depends on sfb_pkg.
module sfb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sfb_pkg::cmd_t       cmd,
    output sfb_pkg::sts_t       sts,
    input  logic [1:0]          leg,
    input  logic [31:0]         now_time,
    input  logic signed [23:0]  start_x,
    input  logic signed [23:0]  start_y,
    input  logic signed [23:0]  end_x,
    input  logic signed [23:0]  end_y,
    input  logic [23:0]         period,
    input  logic signed [23:0]  z_point0,
    input  logic signed [23:0]  z_point1,
    input  logic signed [23:0]  z_point2,
    input  logic signed [23:0]  z_point3,
    output logic [1:0]          leg_out,
    output logic signed [23:0]  pos_x,
    output logic signed [23:0]  pos_y,
    output logic signed [23:0]  pos_z,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  vel_z,
    output logic                vel_saturated
);

    logic signed [23:0] sx_reg [sfb_pkg::LEGS];
    logic signed [23:0] sy_reg [sfb_pkg::LEGS];
    logic signed [23:0] ex_reg [sfb_pkg::LEGS];
    logic signed [23:0] ey_reg [sfb_pkg::LEGS];
    logic [31:0]        ref_reg [sfb_pkg::LEGS];

    logic [5:0]  cnt_reg;
    logic [23:0] r_reg;
    logic [47:0] d_reg;

    logic [1:0]         leg_reg;
    logic signed [23:0] p_reg [3][4];
    logic signed [23:0] w_reg [4];
    logic signed [24:0] dd_reg [3];
    logic [18:0]        u_reg;
    logic [15:0]        t_reg;
    logic               sat_reg;
    logic signed [39:0] vv_reg, vu_reg;
    logic [37:0]        uu_reg;
    logic signed [23:0] c_reg [3];
    logic signed [41:0] lprod_reg;
    logic signed [48:0] vprod_reg;
    logic signed [50:0] acc_reg;
    logic               neg_reg;
    logic [32:0]        m_reg;
    logic [52:0]        n_reg;
    logic               ovf_reg;
    logic signed [23:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];

    logic [1:0]         leg_out_reg;
    logic signed [23:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg, vel_z_reg;
    logic               vel_sat_reg;

    logic               leg_ok;
    logic signed [23:0] ax_rd, ay_rd, bx_rd, by_rd;
    logic [31:0]        ref_rd, elapsed_w;
    logic [24:0]        rr_w, rsub_w;
    logic               ge_w;
    logic               over_w;
    logic signed [19:0] u_s, v_s;
    logic signed [41:0] c0_w, c1_w, c2_w, uu_x;
    logic signed [24:0] ldiff_w;
    logic signed [23:0] lerp_new_w;
    logic signed [50:0] dr_w;
    logic [31:0]        q_w, vel_w;
    logic               vsat_w;

    assign leg_ok = int'(leg) < sfb_pkg::LEGS;
    assign ax_rd  = leg_ok ? sx_reg[leg] : '0;
    assign ay_rd  = leg_ok ? sy_reg[leg] : '0;
    assign bx_rd  = leg_ok ? ex_reg[leg] : '0;
    assign by_rd  = leg_ok ? ey_reg[leg] : '0;
    assign ref_rd = leg_ok ? ref_reg[leg] : '0;
    assign elapsed_w = now_time - ref_rd;

    assign rr_w   = {r_reg, d_reg[47]};
    assign ge_w   = rr_w >= {1'b0, period};
    assign rsub_w = rr_w - {1'b0, period};
    assign sts.div_last = (cnt_reg == 6'd1);

    assign over_w = d_reg > 48'(sfb_pkg::PHASE_MAX);

    assign u_s  = {1'b0, u_reg};
    assign v_s  = 20'sd65536 - u_s;
    assign uu_x = $signed({4'b0, uu_reg});
    assign c0_w = ((42'(vv_reg) <<< 1) + 42'(vv_reg) + 42'sd32768) >>> 16;
    assign c1_w = ((42'(vu_reg) <<< 2) + (42'(vu_reg) <<< 1) + 42'sd32768) >>> 16;
    assign c2_w = ((uu_x <<< 1) + uu_x + 42'sd32768) >>> 16;

    assign ldiff_w    = 25'(w_reg[1]) - 25'(w_reg[0]);
    assign lerp_new_w = w_reg[0] + 24'((lprod_reg + 42'sd32768) >>> 16);

    assign dr_w = (acc_reg + 51'sd32768) >>> 16;

    assign q_w = d_reg[31:0];
    always_comb
    begin
        vsat_w = 1'b0;
        vel_w  = q_w;
        if (neg_reg)
        begin
            if (ovf_reg || (q_w > 32'h8000_0000))
            begin
                vsat_w = 1'b1;
                vel_w  = 32'h8000_0000;
            end
            else
            begin
                vel_w = 32'd0 - q_w;
            end
        end
        else if (ovf_reg || (q_w > 32'h7FFF_FFFF))
        begin
            vsat_w = 1'b1;
            vel_w  = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfb_pkg::LEGS; i++)
            begin
                sx_reg[i]  <= '0;
                sy_reg[i]  <= '0;
                ex_reg[i]  <= '0;
                ey_reg[i]  <= '0;
                ref_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.store && leg_ok)
            begin
                sx_reg[leg]  <= start_x;
                sy_reg[leg]  <= start_y;
                ex_reg[leg]  <= end_x;
                ey_reg[leg]  <= end_y;
                ref_reg[leg] <= now_time;
            end
            if (cmd.capture)
            begin
                cnt_reg <= sfb_pkg::DIV_STEPS_PHASE;
            end
            else if (cmd.div_load_vel)
            begin
                cnt_reg <= sfb_pkg::DIV_STEPS_VEL;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            leg_reg    <= leg;
            p_reg[0][0] <= ax_rd;
            p_reg[0][1] <= sfb_pkg::inner_pt(ax_rd, bx_rd);
            p_reg[0][2] <= sfb_pkg::inner_pt(bx_rd, ax_rd);
            p_reg[0][3] <= bx_rd;
            p_reg[1][0] <= ay_rd;
            p_reg[1][1] <= sfb_pkg::inner_pt(ay_rd, by_rd);
            p_reg[1][2] <= sfb_pkg::inner_pt(by_rd, ay_rd);
            p_reg[1][3] <= by_rd;
            p_reg[2][0] <= z_point0;
            p_reg[2][1] <= z_point1;
            p_reg[2][2] <= z_point2;
            p_reg[2][3] <= z_point3;
            r_reg <= '0;
            d_reg <= {elapsed_w, 16'b0};
        end
        else if (cmd.div_load_vel)
        begin
            r_reg   <= {3'b0, n_reg[52:32]};
            d_reg   <= {n_reg[31:0], 16'b0};
            ovf_reg <= {3'b0, n_reg[52:32]} >= period;
        end
        else if (cmd.div_step)
        begin
            r_reg <= ge_w ? rsub_w[23:0] : rr_w[23:0];
            d_reg <= {d_reg[46:0], ge_w};
        end

        if (cmd.phase_take)
        begin
            u_reg   <= over_w ? sfb_pkg::PHASE_MAX : d_reg[18:0];
            t_reg   <= d_reg[15:0];
            sat_reg <= over_w;
        end
        else if (cmd.vtake)
        begin
            sat_reg <= sat_reg | vsat_w;
        end

        if (cmd.coef_mul)
        begin
            vv_reg <= v_s * v_s;
            vu_reg <= v_s * u_s;
            uu_reg <= u_reg * u_reg;
        end
        if (cmd.coef_fin)
        begin
            c_reg[0] <= c0_w[23:0];
            c_reg[1] <= c1_w[23:0];
            c_reg[2] <= c2_w[23:0];
        end

        if (cmd.axis_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i] <= p_reg[cmd.axis][i];
            end
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= 25'(p_reg[cmd.axis][i + 1]) - 25'(p_reg[cmd.axis][i]);
            end
        end
        else if (cmd.wshift || cmd.lerp_add)
        begin
            w_reg[0] <= w_reg[1];
            w_reg[1] <= w_reg[2];
            w_reg[2] <= w_reg[3];
            w_reg[3] <= cmd.lerp_add ? lerp_new_w : w_reg[3];
        end
        if (cmd.lerp_mul)
        begin
            lprod_reg <= ldiff_w * $signed({1'b0, t_reg});
        end
        if (cmd.pos_take)
        begin
            pos_reg[cmd.axis] <= w_reg[3];
        end

        if (cmd.vmul)
        begin
            vprod_reg <= c_reg[cmd.vk] * dd_reg[cmd.vk];
        end
        if (cmd.vclr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.vacc)
        begin
            acc_reg <= acc_reg + 51'(vprod_reg);
        end
        if (cmd.vround)
        begin
            neg_reg <= dr_w[50];
            m_reg   <= dr_w[50] ? 33'(-dr_w) : 33'(dr_w);
        end
        if (cmd.vscale)
        begin
            n_reg <= 53'(m_reg) * 53'(sfb_pkg::US_PER_S) + 53'(period >> 1);
        end
        if (cmd.vtake)
        begin
            vel_reg[cmd.axis] <= vel_w;
        end

        if (cmd.result_load)
        begin
            leg_out_reg <= leg_reg;
            pos_x_reg   <= pos_reg[0];
            pos_y_reg   <= pos_reg[1];
            pos_z_reg   <= pos_reg[2];
            vel_x_reg   <= vel_reg[0];
            vel_y_reg   <= vel_reg[1];
            vel_z_reg   <= vel_reg[2];
            vel_sat_reg <= sat_reg;
        end
    end

    assign leg_out       = leg_out_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign vel_x         = vel_x_reg;
    assign vel_y         = vel_y_reg;
    assign vel_z         = vel_z_reg;
    assign vel_saturated = vel_sat_reg;

endmodule

[tb/tb_swing_foot_bezier_trajectory_top.sv]
// Swing foot trajectory testbench: directed table, then random set/query traffic per config.
// Expected results come from a self-contained predictor of the Bezier position and velocity.
// Depends on sfb_pkg and swing_foot_bezier_trajectory_top.
module tb_swing_foot_bezier_trajectory_top;

    typedef struct {
        logic               kind;
        logic [1:0]         leg;
        logic [31:0]        now;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
    } foot_cmd_t;

    typedef struct {
        logic [1:0]         leg;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               sat;
    } foot_state_t;

    typedef struct {
        foot_cmd_t   cmd;
        bit          typed;
        foot_state_t res;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = 1'b0;
    logic [1:0]         leg = '0;
    logic [31:0]        now_time = '0;
    logic signed [23:0] start_x = '0;
    logic signed [23:0] start_y = '0;
    logic signed [23:0] end_x = '0;
    logic signed [23:0] end_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         leg_out;
    logic signed [23:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic               vel_saturated;

    swing_foot_bezier_trajectory_top dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [23:0]        m_period;
    logic signed [23:0] m_z [4];
    logic signed [23:0] m_ax [4], m_ay [4], m_bx [4], m_by [4];
    logic [31:0]        m_ref [4];

    foot_state_t pending_q [$];
    plan_row_t   plan [$];
    int          errors = 0;
    int          n_rx = 0;
    longint      cycles = 0;
    bit          tx_burst = 0;
    bit          rx_burst = 0;

    function automatic longint lerp16(longint a, longint b, longint t);
        return a + (((b - a) * t + 32768) >>> 16);
    endfunction

    function automatic longint bez_pos(longint p0, longint p1, longint p2, longint p3,
                                       longint t);
        longint a, b, c;
        a = lerp16(p0, p1, t);
        b = lerp16(p1, p2, t);
        c = lerp16(p2, p3, t);
        return lerp16(lerp16(a, b, t), lerp16(b, c, t), t);
    endfunction

    function automatic longint bez_vel(longint p0, longint p1, longint p2, longint p3,
                                       longint u, longint per, inout bit clip);
        longint v, c0, c1, c2, d, m, q;
        v  = 65536 - u;
        c0 = (3 * v * v + 32768) >>> 16;
        c1 = (6 * v * u + 32768) >>> 16;
        c2 = (3 * u * u + 32768) >>> 16;
        d  = (c0 * (p1 - p0) + c1 * (p2 - p1) + c2 * (p3 - p2) + 32768) >>> 16;
        m  = (d < 0) ? -d : d;
        q  = (m * 1000000 + per / 2) / per;
        if (d < 0)
        begin
            if (q > 64'sd2147483648)
            begin
                clip = 1;
                q = 64'sd2147483648;
            end
            return -q;
        end
        if (q > 64'sd2147483647)
        begin
            clip = 1;
            q = 64'sd2147483647;
        end
        return q;
    endfunction

    function automatic foot_state_t predict_foot(logic [1:0] lg, logic [31:0] now);
        foot_state_t r;
        longint ax, ay, bx, by, per, el, t, u;
        logic [31:0] el32;
        bit clip;
        longint vx, vy, vz, ppx, ppy, ppz;
        ax = m_ax[lg];
        ay = m_ay[lg];
        bx = m_bx[lg];
        by = m_by[lg];
        per = (m_period == 0) ? 1 : longint'(m_period);
        el32 = now - m_ref[lg];
        el = el32;
        t = ((el % per) << 16) / per;
        u = (el << 16) / per;
        clip = 0;
        if (u > 262144)
        begin
            u = 262144;
            clip = 1;
        end
        vx = bez_vel(ax, (3 * ax + bx) >>> 2, (ax + 3 * bx) >>> 2, bx, u, per, clip);
        vy = bez_vel(ay, (3 * ay + by) >>> 2, (ay + 3 * by) >>> 2, by, u, per, clip);
        vz = bez_vel(m_z[0], m_z[1], m_z[2], m_z[3], u, per, clip);
        ppx = bez_pos(ax, (3 * ax + bx) >>> 2, (ax + 3 * bx) >>> 2, bx, t);
        ppy = bez_pos(ay, (3 * ay + by) >>> 2, (ay + 3 * by) >>> 2, by, t);
        ppz = bez_pos(m_z[0], m_z[1], m_z[2], m_z[3], t);
        r.leg = lg;
        r.px  = ppx[23:0];
        r.py  = ppy[23:0];
        r.pz  = ppz[23:0];
        r.vx  = vx[31:0];
        r.vy  = vy[31:0];
        r.vz  = vz[31:0];
        r.sat = clip;
        return r;
    endfunction

    task automatic cfg_write(sfb_pkg::cfg_idx_t idx, logic [23:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sfb_pkg::CFG_PERIOD: m_period = d;
            sfb_pkg::CFG_Z0:     m_z[0] = d;
            sfb_pkg::CFG_Z1:     m_z[1] = d;
            sfb_pkg::CFG_Z2:     m_z[2] = d;
            sfb_pkg::CFG_Z3:     m_z[3] = d;
            default: ;
        endcase
    endtask

    task automatic configure(logic [23:0] per, logic [23:0] z0, logic [23:0] z1,
                             logic [23:0] z2, logic [23:0] z3);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_write(sfb_pkg::CFG_PERIOD, per);
        cfg_write(sfb_pkg::CFG_Z0, z0);
        cfg_write(sfb_pkg::CFG_Z1, z1);
        cfg_write(sfb_pkg::CFG_Z2, z2);
        cfg_write(sfb_pkg::CFG_Z3, z3);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_cmd(foot_cmd_t c, bit typed, foot_state_t r);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= c.kind;
        leg      <= c.leg;
        now_time <= c.now;
        start_x  <= c.sx;
        start_y  <= c.sy;
        end_x    <= c.ex;
        end_y    <= c.ey;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c.kind == sfb_pkg::KIND_SET)
        begin
            m_ax[c.leg]  = c.sx;
            m_ay[c.leg]  = c.sy;
            m_bx[c.leg]  = c.ex;
            m_by[c.leg]  = c.ey;
            m_ref[c.leg] = c.now;
        end
        else
            pending_q.push_back(typed ? r : predict_foot(c.leg, c.now));
    endtask

    task automatic add_row(logic k, logic [1:0] lg, logic [31:0] now,
                           logic [23:0] sx, logic [23:0] sy, logic [23:0] ex,
                           logic [23:0] ey);
        plan_row_t p;
        p.cmd = '{k, lg, now, sx, sy, ex, ey};
        p.typed = 0;
        p.res = '{0, 0, 0, 0, 0, 0, 0, 0};
        plan.push_back(p);
    endtask

    task automatic random_phase(int n);
        foot_cmd_t c;
        foot_state_t none;
        longint per, el;
        none = '{0, 0, 0, 0, 0, 0, 0, 0};
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            c.leg = 2'($urandom_range(0, 3));
            c.sx  = 24'($urandom);
            c.sy  = 24'($urandom);
            c.ex  = 24'($urandom);
            c.ey  = 24'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                c.sx = $signed(c.sx) >>> 4;
                c.ex = $signed(c.ex) >>> 4;
            end
            per = (m_period == 0) ? 1 : longint'(m_period);
            if ($urandom_range(0, 9) < 4)
            begin
                c.kind = sfb_pkg::KIND_SET;
                c.now  = $urandom;
            end
            else
            begin
                c.kind = sfb_pkg::KIND_QUERY;
                if ($urandom_range(0, 7) == 0)
                    c.now = $urandom;
                else
                begin
                    el = $urandom_range(0, 32'(5 * per));
                    c.now = m_ref[c.leg] + el[31:0];
                end
            end
            send_cmd(c, 0, none);
        end
        tx_burst = 0;
    endtask

    // receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        int stall;
        foot_state_t e;
        wait (rst_n === 1'b1);
        forever
        begin
            if (n_rx % 30 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (n_rx == 60)
                stall = 3000;
            else
                stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            n_rx++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result transfer, leg %0d", leg_out);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (leg_out !== e.leg)
                begin
                    $error("leg_out exp %0d got %0d", e.leg, leg_out);
                    errors++;
                end
                if (pos_x !== e.px)
                begin
                    $error("pos_x exp %0d got %0d", e.px, pos_x);
                    errors++;
                end
                if (pos_y !== e.py)
                begin
                    $error("pos_y exp %0d got %0d", e.py, pos_y);
                    errors++;
                end
                if (pos_z !== e.pz)
                begin
                    $error("pos_z exp %0d got %0d", e.pz, pos_z);
                    errors++;
                end
                if (vel_x !== e.vx)
                begin
                    $error("vel_x exp %0d got %0d", e.vx, vel_x);
                    errors++;
                end
                if (vel_y !== e.vy)
                begin
                    $error("vel_y exp %0d got %0d", e.vy, vel_y);
                    errors++;
                end
                if (vel_z !== e.vz)
                begin
                    $error("vel_z exp %0d got %0d", e.vz, vel_z);
                    errors++;
                end
                if (vel_saturated !== e.sat)
                begin
                    $error("vel_saturated exp %0d got %0d", e.sat, vel_saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t p;
        m_period = sfb_pkg::PERIOD_RESET;
        m_z[0] = sfb_pkg::Z_OUTER_RESET;
        m_z[1] = sfb_pkg::Z_INNER_RESET;
        m_z[2] = sfb_pkg::Z_INNER_RESET;
        m_z[3] = sfb_pkg::Z_OUTER_RESET;
        for (int i = 0; i < 4; i++)
        begin
            m_ax[i] = 0;
            m_ay[i] = 0;
            m_bx[i] = 0;
            m_by[i] = 0;
            m_ref[i] = 0;
        end

        // after reset: zero legs, z at its start point, z velocity from default period
        p.cmd = '{sfb_pkg::KIND_QUERY, 2'd0, 32'd0, 24'd0, 24'd0, 24'd0, 24'd0};
        p.typed = 1;
        p.res = '{2'd0, 24'sd0, 24'sd0, -24'sd340787, 32'sd0, 32'sd0, 32'sd943716, 1'b0};
        plan.push_back(p);
        add_row(sfb_pkg::KIND_QUERY, 2'd1, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_SET, 2'd0, 32'd0, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000,
                24'h7F_FFFF);
        add_row(sfb_pkg::KIND_QUERY, 2'd0, 32'd0, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd0, 32'd125000, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd0, 32'd249999, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd0, 32'd250000, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd0, 32'd1000000, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd0, 32'd1000001, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_SET, 2'd3, 32'hFFFF_FFF0, 24'h80_0000, 24'h7F_FFFF,
                24'h7F_FFFF, 24'h80_0000);
        add_row(sfb_pkg::KIND_QUERY, 2'd3, 32'd10, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd3, 32'd700000, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_SET, 2'd1, 32'd5000, 24'h01_0000, 24'hFF_0000, 24'h10_0000,
                24'h00_0003);
        add_row(sfb_pkg::KIND_QUERY, 2'd1, 32'd67500, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_SET, 2'd2, 32'd100, 24'hFF_FFFF, 24'h00_0001, 24'h00_0000,
                24'hFF_FFFD);
        add_row(sfb_pkg::KIND_QUERY, 2'd2, 32'd50, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd2, 32'd180100, 0, 0, 0, 0);
        add_row(sfb_pkg::KIND_QUERY, 2'd1, 32'h8000_0000, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_cmd(plan[i].cmd, plan[i].typed, plan[i].res);
        random_phase(340);
        in_valid <= 1'b0;

        configure(24'd1, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000);
        random_phase(340);
        in_valid <= 1'b0;
        configure(24'hFF_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
        random_phase(340);
        in_valid <= 1'b0;
        configure(24'd0, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        random_phase(340);
        in_valid <= 1'b0;
        configure(24'($urandom_range(1000, 1000000)), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom));
        random_phase(340);
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
